### src/bmhq_pkg.sv
// Package: command and status codes and the heap entry type for the max-heap queue.
package bmhq_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_CLEAR  = 3'd4
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [15:0] prio;
        logic [31:0]        stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### src/binary_max_heap_queue.sv
// Top level: binary max-heap priority queue held in one RAM, run by a small sequencer.
//
// Binary max-heap of up to CAPACITY entries (16-bit signed priority, 32-bit arrival
// stamp) kept in a single RAM with one write and one registered read port. One command
// is in work at a time; s_tready is high only while the sequencer is idle, and a
// finished result may wait in the output register while the next command is taken.
// Run time is set by the RAM read port and a single shared priority comparator: clear,
// unused codes and flagged commands go straight to the result, peek and lookup read
// the RAM once, insert reads one parent per level climbed, up to log2(CAPACITY) levels,
// and delete reads the root and the last entry, then the children per level descended,
// up to log2(CAPACITY) - 1 levels.
// Insert hands back the new stamp; delete and peek the root's priority and stamp;
// lookup the stamp at a heap position. occupancy is the entry count after the command.
module binary_max_heap_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[2:0], new_priority[18:3], position[28:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status[1:0], out_priority[17:2], out_stamp[49:18],
                                   // occupancy[60:50]
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = IW + 2;
    localparam int PCW = (CW > 10) ? CW : 10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DEL_ROOT,
        S_DEL_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_READ_OUT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [31:0]         stamp_reg, stamp_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       cidx_reg, cidx_next;
    bmhq_pkg::entry_t    x_reg, x_next;
    bmhq_pkg::entry_t    child_reg, child_next;
    logic                look_reg, look_next;
    bmhq_pkg::status_t   res_status_reg, res_status_next;
    logic [15:0]         res_prio_reg, res_prio_next;
    logic [31:0]         res_stamp_reg, res_stamp_next;
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_data_reg, m_data_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    bmhq_pkg::entry_t    ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [bmhq_pkg::ENTRY_W-1:0] ram_rdata_raw;
    bmhq_pkg::entry_t    ram_rdata;

    logic signed [15:0]  cmp_a, cmp_b;
    logic                a_gt_b;

    logic [2:0]          in_cmd;
    logic [15:0]         in_prio;
    logic [9:0]          in_pos;
    logic [LW-1:0]       left_idx, right_idx;
    logic [LW-1:0]       cnt_ext;
    logic                accept;

    assign in_cmd    = s_tdata[2:0];
    assign in_prio   = s_tdata[18:3];
    assign in_pos    = s_tdata[28:19];
    assign ram_rdata = bmhq_pkg::entry_t'(ram_rdata_raw);
    assign left_idx  = {1'b0, idx_reg, 1'b1};
    assign right_idx = left_idx + LW'(1);
    assign cnt_ext   = LW'(cnt_reg);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // the one priority comparator, shared by every sift step
    assign a_gt_b = cmp_a > cmp_b;

    always_comb
    begin
        cmp_a = ram_rdata.prio;
        cmp_b = child_reg.prio;
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = x_reg.prio;
                cmp_b = ram_rdata.prio;
            end
            S_DN_CMP:
            begin
                cmp_a = child_reg.prio;
                cmp_b = x_reg.prio;
            end
            default:
            begin
                cmp_a = ram_rdata.prio;
                cmp_b = child_reg.prio;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        stamp_next      = stamp_reg;
        idx_next        = idx_reg;
        cidx_next       = cidx_reg;
        x_next          = x_reg;
        child_next      = child_reg;
        look_next       = look_reg;
        res_status_next = res_status_reg;
        res_prio_next   = res_prio_reg;
        res_stamp_next  = res_stamp_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = x_reg;
        ram_raddr       = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = bmhq_pkg::ST_OK;
                    res_prio_next   = '0;
                    res_stamp_next  = '0;
                    look_next       = 1'b0;
                    state_next      = S_DONE;
                    unique case (in_cmd)
                        bmhq_pkg::CMD_INSERT:
                        begin
                            if (cnt_reg >= CW'(CAPACITY))
                            begin
                                res_status_next = bmhq_pkg::ST_FULL;
                            end
                            else
                            begin
                                stamp_next     = stamp_reg + 32'd1;
                                x_next.prio    = in_prio;
                                x_next.stamp   = stamp_reg + 32'd1;
                                res_stamp_next = stamp_reg + 32'd1;
                                idx_next       = IW'(cnt_reg);
                                cnt_next       = cnt_reg + CW'(1);
                                state_next     = S_UP_CHK;
                            end
                        end
                        bmhq_pkg::CMD_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = bmhq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = S_DEL_ROOT;
                            end
                        end
                        bmhq_pkg::CMD_PEEK:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = bmhq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = S_READ_OUT;
                            end
                        end
                        bmhq_pkg::CMD_LOOKUP:
                        begin
                            if (PCW'(in_pos) >= PCW'(cnt_reg))
                            begin
                                res_status_next = bmhq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ram_raddr  = IW'(in_pos);
                                look_next  = 1'b1;
                                state_next = S_READ_OUT;
                            end
                        end
                        bmhq_pkg::CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // hole-based sift up: parents move down until the new entry fits
            S_UP_CHK:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cidx_next  = (idx_reg - IW'(1)) >> 1;
                    ram_raddr  = (idx_reg - IW'(1)) >> 1;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (a_gt_b)
                begin
                    ram_wdata  = ram_rdata;
                    idx_next   = cidx_reg;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DEL_ROOT:
            begin
                res_prio_next  = ram_rdata.prio;
                res_stamp_next = ram_rdata.stamp;
                ram_raddr      = IW'(cnt_reg - CW'(1));
                cnt_next       = cnt_reg - CW'(1);
                state_next     = S_DEL_LAST;
            end

            S_DEL_LAST:
            begin
                x_next     = ram_rdata;
                idx_next   = '0;
                state_next = S_DN_CHK;
            end

            // hole-based sift down from the root
            S_DN_CHK:
            begin
                if (left_idx >= cnt_ext)
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = IW'(left_idx);
                    state_next = S_DN_L;
                end
            end

            S_DN_L:
            begin
                child_next = ram_rdata;
                cidx_next  = IW'(left_idx);
                if (right_idx < cnt_ext)
                begin
                    ram_raddr  = IW'(right_idx);
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_R:
            begin
                // right child wins only when strictly greater
                if (a_gt_b)
                begin
                    child_next = ram_rdata;
                    cidx_next  = IW'(right_idx);
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (a_gt_b)
                begin
                    ram_wdata  = child_reg;
                    idx_next   = cidx_reg;
                    state_next = S_DN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_READ_OUT:
            begin
                res_stamp_next = ram_rdata.stamp;
                if (!look_reg)
                begin
                    res_prio_next = ram_rdata.prio;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, 11'(cnt_reg), res_stamp_reg, res_prio_reg,
                                    res_status_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            stamp_reg      <= '0;
            idx_reg        <= '0;
            cidx_reg       <= '0;
            x_reg          <= '0;
            child_reg      <= '0;
            look_reg       <= 1'b0;
            res_status_reg <= bmhq_pkg::ST_OK;
            res_prio_reg   <= '0;
            res_stamp_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            stamp_reg      <= stamp_next;
            idx_reg        <= idx_next;
            cidx_reg       <= cidx_next;
            x_reg          <= x_next;
            child_reg      <= child_next;
            look_reg       <= look_next;
            res_status_reg <= res_status_next;
            res_prio_reg   <= res_prio_next;
            res_stamp_reg  <= res_stamp_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    bmhq_ram #(
        .WIDTH (bmhq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

endmodule

### src/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
